// ===== hdl/direct_mapped_hash_kv_store_top_macros.svh =====
// assertion helpers shared by the store's modules
// they expect signals named clock and reset in the module that uses them
`ifndef DIRECT_MAPPED_HASH_KV_STORE_TOP_MACROS_SVH
`define DIRECT_MAPPED_HASH_KV_STORE_TOP_MACROS_SVH

// condition that holds on every clock edge out of reset
`define DMHKV_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define DMHKV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dmhkv_pkg.sv =====
package dmhkv_pkg;

   // hash: h = seed; h ^= (h << 5) + key + (h >> 2); h &= 28-bit mask
   localparam logic [31:0] HashSeed = 32'd1315423911;
   localparam logic [31:0] HashAdd  = (HashSeed << 5) + (HashSeed >> 2);
   localparam int          HashW    = 28;

   localparam int             ModW     = 11;
   localparam logic [ModW-1:0] ModReset = 11'd509;
   localparam int             CntOutW  = 11;

   // one hash bit per step
   localparam int DivSteps = HashW;
   localparam int DivCntW  = $clog2(DivSteps);

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_GET    = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic div_step;
      logic rd_en;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic nop;
      logic rsp_free;
   } sts_type;

endpackage

// ===== hdl/dmhkv_ctrl.sv =====
`include "direct_mapped_hash_kv_store_top_macros.svh"

module dmhkv_ctrl
   import dmhkv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.nop) begin
               state_in = ST_DONE;
            end else if (sts.div_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         ST_DONE: begin
            cmd.commit = sts.rsp_free;
         end
      endcase
   end

   `DMHKV_ASSERT_NEXT(a_load_leaves_idle, cmd.load, state_ff == ST_DIV, "request load did not start division")
   `DMHKV_ASSERT(a_commit_needs_room, !cmd.commit || sts.rsp_free, "commit while response slot busy")
   `DMHKV_ASSERT_NEXT(a_read_then_done, cmd.rd_en, state_ff == ST_DONE, "bucket read not followed by commit state")

endmodule

// ===== hdl/dmhkv_dp.sv =====
`include "direct_mapped_hash_kv_store_top_macros.svh"

module dmhkv_dp
   import dmhkv_pkg::*;
#(
   parameter int MAX_BUCKETS = 1024,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [ModW-1:0]        csr_wr_data,
   input  logic [1:0]             req_mode,
   input  logic [KEY_WIDTH-1:0]   req_key,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic                   rsp_tready,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_value,
   output logic                   rsp_hit,
   output logic                   rsp_evicted,
   output logic [CntOutW-1:0]     rsp_count
);

   localparam int IDX_W = $clog2(MAX_BUCKETS);
   localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
   localparam int ROW_W = 1 + KEY_WIDTH + VALUE_WIDTH;

   // bucket row: valid, key, value
   logic [ROW_W-1:0]       bucket_mem_ff [MAX_BUCKETS];
   logic [ROW_W-1:0]       rd_data_ff;

   logic [ModW-1:0]        mod_ff;
   logic [ModW-1:0]        mod_eff;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       clr_idx_ff;
   logic [DivCntW-1:0]     div_cnt_ff;
   logic [HashW-1:0]       dvd_ff;
   logic [ModW-1:0]        rem_ff, rem_in;
   logic [ModW:0]          trial;
   mode_type               mode_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;

   logic [KEY_WIDTH+31:0]  key_ext;
   logic [31:0]            hash_sum;
   logic [31:0]            hash_full;
   logic [IDX_W+ModW-1:0]  rem_ext;
   logic [IDX_W-1:0]       bkt_idx;
   logic [CNT_W+CntOutW-1:0] cnt_ext;

   logic                   rd_valid;
   logic [KEY_WIDTH-1:0]   rd_key;
   logic [VALUE_WIDTH-1:0] rd_value;
   logic                   match;

   logic                   op_we;
   logic [ROW_W-1:0]       op_wdata;
   logic                   op_hit;
   logic                   op_evicted;
   logic [VALUE_WIDTH-1:0] op_value;

   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [ROW_W-1:0]       mem_wdata;

   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic                   rsp_hit_ff;
   logic                   rsp_evicted_ff;
   logic [CntOutW-1:0]     rsp_count_ff;

   // hash of the low key word; seed terms fold to constants
   assign key_ext   = (KEY_WIDTH + 32)'(req_key);
   assign hash_sum  = HashAdd + key_ext[31:0];
   assign hash_full = HashSeed ^ hash_sum;

   always_comb begin
      if (mod_ff == '0) begin
         mod_eff = ModW'(1);
      end else if (32'(mod_ff) > 32'(MAX_BUCKETS)) begin
         mod_eff = ModW'(MAX_BUCKETS);
      end else begin
         mod_eff = mod_ff;
      end
   end

   // restoring remainder step
   assign trial = {rem_ff, dvd_ff[HashW-1]};
   always_comb begin
      if (trial >= {1'b0, mod_eff}) begin
         rem_in = ModW'(trial - {1'b0, mod_eff});
      end else begin
         rem_in = trial[ModW-1:0];
      end
   end

   assign rem_ext = (IDX_W + ModW)'(rem_ff);
   assign bkt_idx = rem_ext[IDX_W-1:0];

   assign rd_valid = rd_data_ff[ROW_W-1];
   assign rd_key   = rd_data_ff[KEY_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH];
   assign rd_value = rd_data_ff[VALUE_WIDTH-1:0];
   assign match    = rd_valid && (rd_key == key_ff);

   always_comb begin
      op_we      = 1'b0;
      op_wdata   = {1'b1, key_ff, value_ff};
      op_hit     = 1'b0;
      op_evicted = 1'b0;
      op_value   = '0;
      cnt_in     = cnt_ff;
      unique case (mode_ff)
         MODE_INSERT: begin
            op_we      = 1'b1;
            op_hit     = match;
            op_evicted = rd_valid && !match;
            if (!rd_valid) cnt_in = cnt_ff + CNT_W'(1);
         end
         MODE_REMOVE: begin
            op_hit = match;
            if (match) begin
               op_we    = 1'b1;
               op_wdata = {1'b0, rd_key, rd_value};
               op_value = rd_value;
               if (cnt_ff != '0) cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         MODE_GET: begin
            op_hit = match;
            if (match) op_value = rd_value;
         end
         MODE_NOP: begin
         end
      endcase
   end

   always_comb begin
      if (cmd.clr_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = cmd.commit && op_we;
         mem_waddr = bkt_idx;
         mem_wdata = op_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) bucket_mem_ff[mem_waddr] <= mem_wdata;
      if (cmd.rd_en) rd_data_ff <= bucket_mem_ff[bkt_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff       <= ModReset;
         cnt_ff       <= '0;
         clr_idx_ff   <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) mod_ff <= csr_wr_data;
         if (cmd.clr_step) clr_idx_ff <= clr_idx_ff + IDX_W'(1);
         if (cmd.load) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DivCntW'(1);
         end
         if (cmd.commit) begin
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign cnt_ext = (CNT_W + CntOutW)'(cnt_in);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode_type'(req_mode);
         key_ff   <= req_key;
         value_ff <= req_value;
         dvd_ff   <= hash_full[HashW-1:0];
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[HashW-2:0], 1'b0};
         rem_ff <= rem_in;
      end
      if (cmd.commit) begin
         rsp_value_ff   <= op_value;
         rsp_hit_ff     <= op_hit;
         rsp_evicted_ff <= op_evicted;
         rsp_count_ff   <= cnt_ext[CntOutW-1:0];
      end
   end

   assign sts.clr_last = (clr_idx_ff == IDX_W'(MAX_BUCKETS - 1));
   assign sts.div_last = (div_cnt_ff == DivCntW'(DivSteps - 1));
   assign sts.nop      = (mode_ff == MODE_NOP);
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_evicted = rsp_evicted_ff;
   assign rsp_count   = rsp_count_ff;

   `DMHKV_ASSERT(a_count_bound, 32'(cnt_ff) <= 32'(MAX_BUCKETS), "entry count above bucket capacity")
   `DMHKV_ASSERT(a_clear_excl, !(cmd.clr_step && (cmd.commit || cmd.load)), "clearing pass overlaps a request")
   `DMHKV_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid_ff, "committed response not presented")

endmodule

// ===== hdl/direct_mapped_hash_kv_store_top.sv =====
// Direct-mapped key/value store: each request hashes its key to 28 bits, reduces it modulo
// the bucket count in the csr register (zero acts as one, values above MAX_BUCKETS saturate)
// and inserts, removes or gets in that one bucket; an insert over a different key evicts it.
// A request goes from acceptance to the response register through a load, a bit-serial
// remainder unit, one bucket-memory read and a commit that waits for a free response slot;
// mode three skips the bucket-memory read. After reset a clearing pass marks every bucket
// empty before the first request is accepted. The response sits in an output register, so
// the next request is taken while it waits; write the bucket count only while idle.
module direct_mapped_hash_kv_store_top
   import dmhkv_pkg::*;
#(
   parameter int MAX_BUCKETS = 1024,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   localparam int REQ_W = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((VALUE_WIDTH + 2 + CntOutW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [ModW-1:0]  csr_wr_data,  // bucket_modulus
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,    // key, value, zero pad
   input  logic [1:0]       req_tuser,    // mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata     // value_out, hit, evicted, entry_count, zero pad
);

   cmd_type                cmd;
   sts_type                sts;
   logic [VALUE_WIDTH-1:0] rsp_value;
   logic                   rsp_hit;
   logic                   rsp_evicted;
   logic [CntOutW-1:0]     rsp_count;

   dmhkv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dmhkv_dp #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mode    (req_tuser),
      .req_key     (req_tdata[KEY_WIDTH-1:0]),
      .req_value   (req_tdata[KEY_WIDTH +: VALUE_WIDTH]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_value   (rsp_value),
      .rsp_hit     (rsp_hit),
      .rsp_evicted (rsp_evicted),
      .rsp_count   (rsp_count)
   );

   assign rsp_tdata = RSP_W'({rsp_count, rsp_evicted, rsp_hit, rsp_value});

endmodule

// ===== bench/tb_direct_mapped_hash_kv_store_top.sv =====
`timescale 1ns / 1ps

module tb_direct_mapped_hash_kv_store_top;
   import dmhkv_pkg::*;

   localparam int          TABLE_DEPTH   = 1024;
   localparam logic [31:0] MIX_SEED      = 32'd1315423911;
   localparam int          KEY_POOL_N    = 24;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          LONG_HOLD     = 400;
   localparam int          RUN_LIMIT_NS  = 5_000_000;

   typedef struct {
      mode_type    mode;
      logic [31:0] key;
      logic [31:0] value;
   } store_op_type;

   typedef struct {
      logic [31:0] value_out;
      logic        hit;
      logic        evicted;
      logic [10:0] entry_count;
   } store_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // key, value
   logic [1:0]  req_tuser = '0;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // value_out, hit, evicted, entry_count, zero pad

   direct_mapped_hash_kv_store_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // shadow copy of the table
   logic [31:0] shadow_key [TABLE_DEPTH];
   logic [31:0] shadow_val [TABLE_DEPTH];
   bit          shadow_valid [TABLE_DEPTH];
   int          shadow_count;
   logic [10:0] shadow_modulus;

   store_op_type    pending_ops [$];
   store_reply_type predicted_replies [$];
   logic [31:0]     key_pool [KEY_POOL_N];

   int send_idle_pct;
   int stall_pct;
   bit long_hold_req;
   int hold_left;
   int error_count;
   int ops_accepted;
   int replies_checked;
   int hits_seen;
   int evictions_seen;
   int input_stalls_in_hold;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned bucket_of(logic [31:0] key);
      logic [31:0] h;
      int unsigned m;
      h = MIX_SEED;
      h = h ^ ((h << 5) + key + (h >> 2));
      m = shadow_modulus;
      if (m == 0) m = 1;
      if (m > TABLE_DEPTH) m = TABLE_DEPTH;
      return h[27:0] % m;
   endfunction

   function automatic store_reply_type apply_store_op(store_op_type op);
      store_reply_type r;
      int unsigned     b;
      r.value_out = '0;
      r.hit = 1'b0;
      r.evicted = 1'b0;
      if (op.mode != MODE_NOP) begin
         b = bucket_of(op.key);
         r.hit = shadow_valid[b] && (shadow_key[b] == op.key);
         if (op.mode == MODE_INSERT) begin
            if (!shadow_valid[b])
               shadow_count++;
            else if (!r.hit)
               r.evicted = 1'b1;
            shadow_key[b] = op.key;
            shadow_val[b] = op.value;
            shadow_valid[b] = 1'b1;
         end else if (r.hit) begin
            r.value_out = shadow_val[b];
            if (op.mode == MODE_REMOVE) begin
               shadow_valid[b] = 1'b0;
               if (shadow_count > 0) shadow_count--;
            end
         end
      end
      r.entry_count = shadow_count[10:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      store_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            op.mode = mode_type'(req_tuser);
            op.key = req_tdata[31:0];
            op.value = req_tdata[63:32];
            predicted_replies.push_back(apply_store_op(op));
            ops_accepted++;
         end
         if (hold_left > 0 && req_tvalid && !req_tready)
            input_stalls_in_hold++;
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {op.value, op.key};
               req_tuser <= op.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      store_reply_type want;
      store_reply_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value_out = rsp_tdata[31:0];
            got.hit = rsp_tdata[32];
            got.evicted = rsp_tdata[33];
            got.entry_count = rsp_tdata[44:34];
            if (predicted_replies.size() == 0) begin
               $display("%0t: response with none outstanding: value_out %h hit %b evicted %b count %0d",
                        $time, got.value_out, got.hit, got.evicted, got.entry_count);
               error_count++;
            end else begin
               want = predicted_replies.pop_front();
               replies_checked++;
               if (got.hit) hits_seen++;
               if (got.evicted) evictions_seen++;
               if (got.value_out !== want.value_out) begin
                  $display("%0t: value_out expected %h actual %h", $time, want.value_out,
                           got.value_out);
                  error_count++;
               end
               if (got.hit !== want.hit) begin
                  $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
                  error_count++;
               end
               if (got.evicted !== want.evicted) begin
                  $display("%0t: evicted expected %b actual %b", $time, want.evicted,
                           got.evicted);
                  error_count++;
               end
               if (got.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count expected %0d actual %0d", $time,
                           want.entry_count, got.entry_count);
                  error_count++;
               end
            end
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic push_op(mode_type mode, logic [31:0] key, logic [31:0] value);
      store_op_type op;
      op.mode = mode;
      op.key = key;
      op.value = value;
      pending_ops.push_back(op);
   endtask

   function automatic store_op_type random_op();
      store_op_type op;
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) op.mode = MODE_INSERT;
      else if (sel < 70) op.mode = MODE_GET;
      else if (sel < 95) op.mode = MODE_REMOVE;
      else op.mode = MODE_NOP;
      if ($urandom_range(99) < 80) op.key = key_pool[$urandom_range(KEY_POOL_N - 1)];
      else op.key = $urandom;
      op.value = $urandom;
      return op;
   endfunction

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_tvalid || predicted_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_modulus(logic [10:0] m);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_modulus = m;
   endtask

   task automatic run_random(int n, int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 0; i < n; i++) pending_ops.push_back(random_op());
      wait_drained();
   endtask

   initial begin
      logic [31:0] clash_key;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_key[i] = '0;
         shadow_val[i] = '0;
         shadow_valid[i] = 1'b0;
      end
      shadow_count = 0;
      shadow_modulus = ModReset;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset bucket count, update, eviction, misses, unused mode
      clash_key = 32'h1;
      while (bucket_of(clash_key) != bucket_of(32'h0)) clash_key++;
      push_op(MODE_GET,    32'h0,         32'hFFFF_FFFF);
      push_op(MODE_INSERT, 32'h0,         32'h0);
      push_op(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_op(MODE_GET,    32'h0,         32'h0);
      push_op(MODE_GET,    32'hFFFF_FFFF, 32'h0);
      push_op(MODE_INSERT, 32'h0,         32'h1234_5678);
      push_op(MODE_GET,    32'h0,         32'h0);
      push_op(MODE_INSERT, clash_key,     32'hA5A5_A5A5);
      push_op(MODE_GET,    32'h0,         32'h0);
      push_op(MODE_REMOVE, 32'h0,         32'h0);
      push_op(MODE_REMOVE, clash_key,     32'h0);
      push_op(MODE_GET,    clash_key,     32'h0);
      push_op(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0);
      push_op(MODE_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_drained();

      // zero bucket count acts as a single bucket
      write_modulus(11'd0);
      push_op(MODE_INSERT, 32'h0000_0001, 32'h5555_5555);
      push_op(MODE_INSERT, 32'h8000_0000, 32'hAAAA_AAAA);
      push_op(MODE_GET,    32'h0000_0001, 32'h0);
      push_op(MODE_GET,    32'h8000_0000, 32'h0);
      push_op(MODE_REMOVE, 32'h8000_0000, 32'h0);
      wait_drained();
      run_random(100, 0, 0);

      // above the table size saturates
      write_modulus(11'd2047);
      run_random(150, 72, 0);

      write_modulus(11'd1);
      run_random(100, 0, 72);

      // long output stall with the sender busy so the input backs up
      write_modulus(11'd1024);
      long_hold_req = 1'b1;
      run_random(150, 0, 0);

      write_modulus(11'd7);
      run_random(100, 15, 15);

      write_modulus(11'd509);
      run_random(100, 72, 72);

      $display("tb: %0d requests accepted, %0d responses checked (%0d hits, %0d evictions)",
               ops_accepted, replies_checked, hits_seen, evictions_seen);
      $display("tb: bucket counts 509, 0, 2047, 1, 1024, 7; %0d input stall cycles in long hold",
               input_stalls_in_hold);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
